@@ rtl/core/pwt_pkg.sv @@
// Shared types and constants for the spoke display timing block.
// Holds the command, result and configuration codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwt_pkg;

	// Command codes produced by the front end
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_HALL  = 2'd1,
		OP_PIXEL = 2'd2,
		OP_PRESS = 2'd3
	} op_t;

	// Event kinds reported with each result
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_REV   = 2'd1;
	localparam logic [1:0] KIND_BLANK = 2'd2;
	localparam logic [1:0] KIND_FETCH = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_ROTATION_OFFSET = 3'd0;
	localparam logic [2:0] CFG_MIRROR_ENABLE   = 3'd1;
	localparam logic [2:0] CFG_ANIM_HOLD       = 3'd2;
	localparam logic [2:0] CFG_HALL_DEBOUNCE   = 3'd3;
	localparam logic [2:0] CFG_STANDBY_LIMIT   = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic [7:0]  ANIM_HOLD_RST     = 8'd6;
	localparam logic [7:0]  HALL_DEBOUNCE_RST = 8'd4;
	localparam logic [15:0] STANDBY_LIMIT_RST = 16'd560;

	// Counter limits and address constants
	localparam logic [7:0]  HALL_MAX   = 8'hff;
	localparam logic [15:0] LAP_MAX    = 16'hffff;
	localparam logic [15:0] LAP_LOW    = 16'h0003;
	localparam logic [15:0] LAP_HIGH   = 16'h00ff;
	localparam logic [15:0] FRAME_STEP = 16'd1024;
	localparam logic [10:0] COL_SPAN   = 11'd1024;
	localparam logic [9:0]  COL_STEP   = 10'd4;

	// Classified command passed from front end to back end
	typedef struct packed {
		op_t        op;
		logic [7:0] sub_tick;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/pwt_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface pwt_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] sub_tick;

	modport source (output valid, output mode, output sub_tick, input ready);
	modport sink (input valid, input mode, input sub_tick, output ready);
endinterface

interface pwt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [15:0] pixel_period;
	logic [15:0] front_addr;
	logic [15:0] back_addr;
	logic        back_valid;
	logic        timer_running;
	logic        sleep_request;

	modport source (output valid, output event_kind, output pixel_period, output front_addr,
		output back_addr, output back_valid, output timer_running, output sleep_request,
		input ready);
	modport sink (input valid, input event_kind, input pixel_period, input front_addr,
		input back_addr, input back_valid, input timer_running, input sleep_request,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/pov_wheel_pixel_timing_top.sv @@
// Spoke display timing top level: front end, command queue, back end.
// A result passes the front-end register, the command queue and the result register.
// Throughput: one transaction per cycle unless results stall; set by back-end update.
// Every transaction yields exactly one result transaction.
// Reset (arst_n low, asynchronous) clears all counters and restores register defaults.
// Depends on pwt_pkg, pwt_if, pwt_front, pwt_queue and pwt_back.
`timescale 1ns / 1ps
`default_nettype none

module pov_wheel_pixel_timing_top
	import pwt_pkg::*;
#(
	parameter int PIXELS_PER_REV = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pwt_in_if.sink                     items,
	pwt_out_if.source                  results,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t fe_cmd;
	logic fe_valid;
	logic fe_ready;
	cmd_t be_cmd;
	logic be_valid;
	logic be_ready;

	pwt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd       (fe_cmd),
		.cmd_valid (fe_valid),
		.cmd_ready (fe_ready)
	);

	pwt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (fe_cmd),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.pop_cmd    (be_cmd),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready)
	);

	pwt_back #(
		.PIXELS_PER_REV (PIXELS_PER_REV)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (be_cmd),
		.cmd_valid (be_valid),
		.cmd_ready (be_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.results   (results)
	);

endmodule

`default_nettype wire

@@ rtl/core/pwt_front.sv @@
// Front end: accepts input transactions and classifies them into commands.
// Depends on pwt_pkg and pwt_in_if.
`timescale 1ns / 1ps
`default_nettype none

module pwt_front
	import pwt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pwt_in_if.sink    items,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  wire logic cmd_ready
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic take;

	// Accept when the stage is empty or drains this cycle
	assign items.ready = !valid_s1 || cmd_ready;
	assign take        = items.valid && items.ready;

	// Hold the classified command until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op       <= op_t'(items.mode);
			cmd_s1.sub_tick <= items.sub_tick;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

`default_nettype wire

@@ rtl/core/pwt_queue.sv @@
// Two-entry command queue between front end and back end.
// Depends on pwt_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module pwt_queue
	import pwt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t push_cmd,
	input  wire logic push_valid,
	output logic      push_ready,
	output cmd_t      pop_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pwt_back.sv @@
// Back end: configuration registers, wheel timing state and result register.
// Depends on pwt_pkg and pwt_out_if.
`timescale 1ns / 1ps
`default_nettype none

module pwt_back
	import pwt_pkg::*;
#(
	parameter int PIXELS_PER_REV = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	pwt_out_if.source                  results
);

	// Start column of each offset, reduced modulo the pixel count
	function automatic logic [256*8-1:0] mod_table(input int ppr);
		logic [256*8-1:0] t;
		int               r;
		t = '0;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i*8 +: 8] = 8'(r);
			if (r == ppr - 1) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return t;
	endfunction

	localparam logic [256*8-1:0] MOD_TBL = mod_table(PIXELS_PER_REV);

	// Configuration
	logic [7:0]  rotation_offset_q;
	logic        mirror_enable_q;
	logic [7:0]  anim_hold_q;
	logic [7:0]  hall_debounce_q;
	logic [15:0] standby_limit_q;

	// Timing state
	logic [7:0]  hall_count_q;
	logic [15:0] lap_count_q;
	logic [7:0]  anim_count_q;
	logic [15:0] frame_offset_q;
	logic [9:0]  column_addr_q;
	logic        mirror_latched_q;
	logic        running_q;
	logic [15:0] period_q;

	// Next values
	logic [7:0]  hall_count_d;
	logic [15:0] lap_count_d;
	logic [7:0]  anim_count_d;
	logic [15:0] frame_offset_d;
	logic [9:0]  column_addr_d;
	logic        mirror_latched_d;
	logic        running_d;
	logic [15:0] period_d;
	logic [1:0]  kind_d;
	logic [15:0] pix_period_d;
	logic [15:0] front_d;
	logic [15:0] back_d;
	logic        bvalid_d;

	// Result register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] pix_period_q;
	logic [15:0] front_q;
	logic [15:0] back_q;
	logic        bvalid_q;
	logic        run_out_q;
	logic        sleep_q;

	logic        step;
	logic [7:0]  start_col;
	logic [10:0] tbl_idx;

	// Take a command whenever the result register is free or drains
	assign cmd_ready = !out_valid_q || results.ready;
	assign step      = cmd_valid && cmd_ready;
	assign tbl_idx   = {rotation_offset_q, 3'b000};
	assign start_col = MOD_TBL[tbl_idx +: 8];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_offset_q <= '0;
			mirror_enable_q   <= 1'b0;
			anim_hold_q       <= ANIM_HOLD_RST;
			hall_debounce_q   <= HALL_DEBOUNCE_RST;
			standby_limit_q   <= STANDBY_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROTATION_OFFSET: rotation_offset_q <= cfg_data[7:0];
				CFG_MIRROR_ENABLE:   mirror_enable_q   <= cfg_data[0];
				CFG_ANIM_HOLD:       anim_hold_q       <= cfg_data[7:0];
				CFG_HALL_DEBOUNCE:   hall_debounce_q   <= cfg_data[7:0];
				CFG_STANDBY_LIMIT:   standby_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Execute one command
	always_comb begin
		hall_count_d     = hall_count_q;
		lap_count_d      = lap_count_q;
		anim_count_d     = anim_count_q;
		frame_offset_d   = frame_offset_q;
		column_addr_d    = column_addr_q;
		mirror_latched_d = mirror_latched_q;
		running_d        = running_q;
		period_d         = period_q;
		kind_d           = KIND_NONE;
		pix_period_d     = '0;
		front_d          = '0;
		back_d           = '0;
		bvalid_d         = 1'b0;
		case (cmd.op)
			OP_TICK: begin
				if (hall_count_q != HALL_MAX) begin
					hall_count_d = hall_count_q + 1'b1;
				end
				if (lap_count_q != LAP_MAX) begin
					lap_count_d = lap_count_q + 1'b1;
				end
			end
			OP_HALL: begin
				hall_count_d = '0;
				if (hall_count_q > hall_debounce_q) begin
					if (anim_count_q != anim_hold_q) begin
						anim_count_d = anim_count_q + 1'b1;
					end else begin
						anim_count_d   = '0;
						frame_offset_d = frame_offset_q + FRAME_STEP;
					end
					if (lap_count_q < LAP_HIGH && lap_count_q > LAP_LOW) begin
						period_d         = {lap_count_q[7:0], cmd.sub_tick};
						pix_period_d     = {lap_count_q[7:0], cmd.sub_tick};
						column_addr_d    = {start_col, 2'b00};
						mirror_latched_d = mirror_enable_q;
						running_d        = 1'b1;
						kind_d           = KIND_REV;
					end else begin
						running_d = 1'b0;
						kind_d    = KIND_BLANK;
					end
					lap_count_d = '0;
				end
			end
			OP_PIXEL: begin
				if (running_q) begin
					if (lap_count_q < standby_limit_q) begin
						front_d  = frame_offset_q + {6'b0, column_addr_q};
						bvalid_d = mirror_latched_q;
						if (mirror_latched_q) begin
							back_d = frame_offset_q + {5'b0, COL_SPAN - {1'b0, column_addr_q}};
						end
						column_addr_d = column_addr_q + COL_STEP;
						kind_d        = KIND_FETCH;
					end else begin
						running_d = 1'b0;
						kind_d    = KIND_BLANK;
					end
				end
			end
			OP_PRESS: begin
				lap_count_d = LAP_MAX;
			end
			default: ;
		endcase
	end

	// Update timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hall_count_q     <= '0;
			lap_count_q      <= '0;
			anim_count_q     <= '0;
			frame_offset_q   <= '0;
			column_addr_q    <= '0;
			mirror_latched_q <= 1'b0;
			running_q        <= 1'b0;
			period_q         <= '0;
		end else if (step) begin
			hall_count_q     <= hall_count_d;
			lap_count_q      <= lap_count_d;
			anim_count_q     <= anim_count_d;
			frame_offset_q   <= frame_offset_d;
			column_addr_q    <= column_addr_d;
			mirror_latched_q <= mirror_latched_d;
			running_q        <= running_d;
			period_q         <= period_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_ready) begin
			out_valid_q <= cmd_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (step) begin
			kind_q       <= kind_d;
			pix_period_q <= pix_period_d;
			front_q      <= front_d;
			back_q       <= back_d;
			bvalid_q     <= bvalid_d;
			run_out_q    <= running_d;
			sleep_q      <= (lap_count_d == LAP_MAX);
		end
	end

	assign results.valid         = out_valid_q;
	assign results.event_kind    = kind_q;
	assign results.pixel_period  = pix_period_q;
	assign results.front_addr    = front_q;
	assign results.back_addr     = back_q;
	assign results.back_valid    = bvalid_q;
	assign results.timer_running = run_out_q;
	assign results.sleep_request = sleep_q;

endmodule

`default_nettype wire
